[rtl/lpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants of the length-prefix deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

  // Result kinds, carried on the output tuser
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_BODY   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Size of the message id in bytes
  localparam logic [31:0] ID_BYTES = 32'd4;

  // Register reset values
  localparam logic [16:0] MIN_DATA_LEN_RST  = 17'd4;
  localparam logic [15:0] MAX_BODY_SIZE_RST = 16'hFFFF;

  // Register indexes (byte address / 4)
  localparam logic REG_MIN_DATA_LEN  = 1'b0;
  localparam logic REG_MAX_BODY_SIZE = 1'b1;

  typedef enum logic [1:0] {
    PHASE_LEN  = 2'd0,
    PHASE_ID   = 2'd1,
    PHASE_BODY = 2'd2
  } phase_t;

  typedef struct packed {
    logic [16:0] min_data_len;
    logic [15:0] max_body_size;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] message_id;
    logic [7:0]  body_byte;
    logic        frame_end;
  } result_t;

endpackage

[rtl/lpd_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_cfg_regs
// APB register file holding the length limits.
// ----------------------------------------------------------------------------
module lpd_cfg_regs import lpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Write the selected register; address bits below the word are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_data_len  <= MIN_DATA_LEN_RST;
      cfg.max_body_size <= MAX_BODY_SIZE_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_MIN_DATA_LEN) begin
        cfg.min_data_len <= pwdata[16:0];
      end else begin
        cfg.max_body_size <= pwdata[15:0];
      end
    end
  end

  // Read back
  always_comb begin
    if (paddr[2] == REG_MAX_BODY_SIZE) begin
      prdata = {16'd0, cfg.max_body_size};
    end else begin
      prdata = {15'd0, cfg.min_data_len};
    end
  end

endmodule

[rtl/lpd_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_in_stage
// Input register for the byte stream.
// ----------------------------------------------------------------------------
module lpd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       take,
  output logic       word_valid,
  output logic [7:0] word_byte
);

  assign s_tready = !word_valid || take;

  // Hold the word until the parser takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (s_tready) begin
      word_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      word_byte <= s_tdata;
    end
  end

endmodule

[rtl/lpd_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_parser
// Frame state machine and result register. Assembles the length and id
// fields, checks the length, counts body bytes and emits header, body and error results.
// ----------------------------------------------------------------------------
module lpd_parser import lpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       word_valid,
  input  logic [7:0] word_byte,
  output logic       take,
  output logic       m_tvalid,
  input  logic       m_tready,
  output result_t    res
);

  phase_t      phase, phase_next;
  logic [1:0]  byte_idx, byte_idx_next;
  logic [31:0] length_accum, length_accum_next;
  logic [31:0] id_accum, id_accum_next;
  logic [15:0] body_left, body_left_next;
  logic        emit;
  result_t     res_next;
  logic        fire;
  logic        len_bad;
  logic [16:0] max_len;

  assign take = !m_tvalid || m_tready;
  assign fire = word_valid && take;

  // Length check on the fully assembled field
  assign max_len = {1'b0, cfg.max_body_size} + 17'(ID_BYTES);
  always_comb begin
    len_bad = (length_accum_next < ID_BYTES) ||
              (length_accum_next < {15'd0, cfg.min_data_len}) ||
              (length_accum_next > {15'd0, max_len});
  end

  // Next state
  always_comb begin
    phase_next        = phase;
    byte_idx_next     = byte_idx;
    length_accum_next = length_accum;
    id_accum_next     = id_accum;
    body_left_next    = body_left;
    case (phase)
      PHASE_ID: begin
        id_accum_next = {id_accum[23:0], word_byte};
        byte_idx_next = byte_idx + 2'd1;
        if (byte_idx == 2'd3) begin
          body_left_next = length_accum[15:0] - 16'(ID_BYTES);
          phase_next     = (body_left_next == 16'd0) ? PHASE_LEN : PHASE_BODY;
        end
      end
      PHASE_BODY: begin
        body_left_next = body_left - 16'd1;
        if (body_left_next == 16'd0) begin
          phase_next = PHASE_LEN;
        end
      end
      default: begin
        length_accum_next = {length_accum[23:0], word_byte};
        byte_idx_next     = byte_idx + 2'd1;
        phase_next        = PHASE_LEN;
        if (byte_idx == 2'd3 && !len_bad) begin
          phase_next = PHASE_ID;
        end
      end
    endcase
  end

  // Result for this word
  always_comb begin
    emit     = 1'b0;
    res_next = '0;
    case (phase)
      PHASE_ID: begin
        if (byte_idx == 2'd3) begin
          emit                = 1'b1;
          res_next.kind       = KIND_HEADER;
          res_next.message_id = id_accum_next;
          res_next.frame_end  = (body_left_next == 16'd0);
        end
      end
      PHASE_BODY: begin
        emit                = 1'b1;
        res_next.kind       = KIND_BODY;
        res_next.message_id = id_accum;
        res_next.body_byte  = word_byte;
        res_next.frame_end  = (body_left_next == 16'd0);
      end
      default: begin
        if (byte_idx == 2'd3 && len_bad) begin
          emit          = 1'b1;
          res_next.kind = KIND_ERROR;
        end
      end
    endcase
  end

  // Advance the frame state on each consumed word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PHASE_LEN;
      byte_idx     <= 2'd0;
      length_accum <= 32'd0;
      id_accum     <= 32'd0;
      body_left    <= 16'd0;
    end else if (fire) begin
      phase        <= phase_next;
      byte_idx     <= byte_idx_next;
      length_accum <= length_accum_next;
      id_accum     <= id_accum_next;
      body_left    <= body_left_next;
    end
  end

  // Result register: load, drain or hold
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      res <= res_next;
    end
  end

endmodule

[rtl/length_prefix_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefix_deframer
// Deframer for a byte stream of length-prefixed messages.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one byte per word. Each frame is a 4-byte
//   big-endian length (id plus body), a 4-byte big-endian message id and
//   the body. The master stream gives a header word (tuser 0) once the id
//   is complete, then one word per body byte (tuser 1); tlast marks the last
//   word of the frame. A length below min_data_len or 4, or above
//   max_body_size + 4, gives an error word (tuser 2) and the deframer hunts
//   for the next length field.
//   An accepted byte goes through the input register, then the parser into
//   the result register. Throughput: one byte per cycle while m_tready is
//   high; a result that waits stops the parser, so input stops once the
//   input register is full.
//   Stall: with m_tready low the result holds and s_tready drops once the
//   input register is full; nothing is lost.
//   Reset (rst, synchronous): both streams go empty, the parser returns to
//   collecting a length field and the limits return to 4 and 65535.
//   Registers: min_data_len at 0x0, max_body_size at 0x4; write them only
//   while the stream is idle.
// ----------------------------------------------------------------------------
module length_prefix_deframer import lpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] message_id, [39:32] body_byte
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  result_t    res;
  logic       take;
  logic       word_valid;
  logic [7:0] word_byte;

  lpd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lpd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .take       (take),
    .word_valid (word_valid),
    .word_byte  (word_byte)
  );

  lpd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .word_valid (word_valid),
    .word_byte  (word_byte),
    .take       (take),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .res        (res)
  );

  assign m_tdata = {res.body_byte, res.message_id};
  assign m_tuser = res.kind;
  assign m_tlast = res.frame_end;

endmodule

[rtl/lpd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_checker
// Port-level checks of the deframer output, bound to the top level.
// ----------------------------------------------------------------------------
module lpd_checker import lpd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // Stream is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A stalled word stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word dropped or changed");

  // Error words carry no id, no byte and never close a frame
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_ERROR |-> m_tdata == 40'd0 && !m_tlast)
    else $error("error word carries payload");

  // Header words carry no body byte
  a_header_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_HEADER |-> m_tdata[39:32] == 8'd0)
    else $error("header word carries a body byte");

  // A body word keeps the id of the word before it unless that closed a frame
  a_body_id: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast && m_tuser != KIND_ERROR ##1
    m_tvalid && m_tuser == KIND_BODY |-> m_tdata[31:0] == $past(m_tdata[31:0]))
    else $error("message id changed inside a frame");

endmodule

bind length_prefix_deframer lpd_checker u_lpd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
